// File: rtl/q2rm_pkg.sv
`default_nettype none
package q2rm_pkg;
    localparam int IN_BITS_DEF       = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int NUM_ENT           = 9;
    localparam int OUT_W             = 16;
    localparam int PROD_SHIFT        = 16;
    localparam int CROSS_SHIFT       = 8;
    localparam logic [NUM_ENT-1:0] DIAG_MASK = 9'b100010001;
endpackage
`default_nettype wire

// File: rtl/q2rm_front.sv
`default_nettype none
module q2rm_front import q2rm_pkg::*; #(
    parameter int IN_BITS       = IN_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
    parameter int SW            = 2 * IN_BITS + 18,
    parameter int RW            = SW + OUT_FRAC_BITS + 5
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic signed [IN_BITS-1:0]        i_x,
    input  wire logic signed [IN_BITS-1:0]        i_y,
    input  wire logic signed [IN_BITS-1:0]        i_z,
    input  wire logic signed [IN_BITS-1:0]        i_w,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [NUM_ENT-1:0][RW-1:0]            o_rem,
    output logic [SW:0]                           o_d,
    output logic [NUM_ENT-1:0]                    o_neg,
    output logic                                  o_zero
);
    localparam int PW = 2 * IN_BITS;

    logic                 r_va, r_vb;
    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_xz, r_yz, r_xw, r_yw, r_zw;
    logic                 rdy_a, rdy_b;

    logic [NUM_ENT-1:0][RW-1:0] n_rem;
    logic [SW:0]                n_d;
    logic [NUM_ENT-1:0]         n_neg;
    logic                       n_zero;

    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (rdy_a) begin
            r_va <= i_valid;
        end
        if (rdy_a && i_valid) begin
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_ww <= i_w * i_w;
            r_xy <= i_x * i_y;
            r_xz <= i_x * i_z;
            r_yz <= i_y * i_z;
            r_xw <= i_x * i_w;
            r_yw <= i_y * i_w;
            r_zw <= i_z * i_w;
        end
    end

    always_comb begin
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] p [NUM_ENT];
        logic signed [SW-1:0] hxy, hxz, hyz, lxw, lyw, lzw;
        logic [SW-1:0]        m;
        hxy  = SW'(r_xy) <<< PROD_SHIFT;
        hxz  = SW'(r_xz) <<< PROD_SHIFT;
        hyz  = SW'(r_yz) <<< PROD_SHIFT;
        lxw  = SW'(r_xw) <<< CROSS_SHIFT;
        lyw  = SW'(r_yw) <<< CROSS_SHIFT;
        lzw  = SW'(r_zw) <<< CROSS_SHIFT;
        s    = ((SW'(r_xx) + SW'(r_yy) + SW'(r_zz)) <<< PROD_SHIFT) + SW'(r_ww);
        p[0] = (SW'(r_yy) + SW'(r_zz)) <<< PROD_SHIFT;
        p[1] = hxy + lzw;
        p[2] = hxz - lyw;
        p[3] = hxy - lzw;
        p[4] = (SW'(r_xx) + SW'(r_zz)) <<< PROD_SHIFT;
        p[5] = hyz + lxw;
        p[6] = hxz + lyw;
        p[7] = hyz - lxw;
        p[8] = (SW'(r_xx) + SW'(r_yy)) <<< PROD_SHIFT;
        for (int i = 0; i < NUM_ENT; i++) begin
            n_neg[i] = p[i][SW-1];
            m        = n_neg[i] ? SW'(-p[i]) : SW'(p[i]);
            n_rem[i] = (RW'(m) << (OUT_FRAC_BITS + 2)) + RW'(s);
        end
        n_d    = {s, 1'b0};
        n_zero = (s == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (rdy_b) begin
            r_vb <= r_va;
        end
        if (rdy_b && r_va) begin
            o_rem  <= n_rem;
            o_d    <= n_d;
            o_neg  <= n_neg;
            o_zero <= n_zero;
        end
    end
endmodule
`default_nettype wire

// File: rtl/q2rm_div_cell.sv
`default_nettype none
module q2rm_div_cell import q2rm_pkg::*; #(
    parameter int SW     = 50,
    parameter int RW     = 69,
    parameter int QW     = 18,
    parameter int BIT_K  = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [NUM_ENT-1:0][RW-1:0]   i_rem,
    input  wire logic [NUM_ENT-1:0][QW-1:0]   i_q,
    input  wire logic [SW:0]                  i_d,
    input  wire logic [NUM_ENT-1:0]           i_neg,
    input  wire logic                         i_zero,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [NUM_ENT-1:0][RW-1:0]        o_rem,
    output logic [NUM_ENT-1:0][QW-1:0]        o_q,
    output logic [SW:0]                       o_d,
    output logic [NUM_ENT-1:0]                o_neg,
    output logic                              o_zero
);
    logic                       r_valid;
    logic [RW-1:0]              t;
    logic [NUM_ENT-1:0][RW-1:0] n_rem;
    logic [NUM_ENT-1:0][QW-1:0] n_q;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign t       = RW'(i_d) << BIT_K;

    always_comb begin
        for (int i = 0; i < NUM_ENT; i++) begin
            if (i_rem[i] >= t) begin
                n_rem[i] = i_rem[i] - t;
                n_q[i]   = i_q[i] | (QW'(1) << BIT_K);
            end else begin
                n_rem[i] = i_rem[i];
                n_q[i]   = i_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            o_rem  <= n_rem;
            o_q    <= n_q;
            o_d    <= i_d;
            o_neg  <= i_neg;
            o_zero <= i_zero;
        end
    end
endmodule
`default_nettype wire

// File: rtl/q2rm_back.sv
`default_nettype none
module q2rm_back import q2rm_pkg::*; #(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
    parameter int QW            = OUT_FRAC_BITS + 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [NUM_ENT-1:0][QW-1:0]   i_q,
    input  wire logic [NUM_ENT-1:0]           i_neg,
    input  wire logic                         i_zero,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [NUM_ENT*OUT_W-1:0]          o_data
);
    localparam int VW = OUT_FRAC_BITS + 6;

    logic                       r_valid;
    logic [NUM_ENT*OUT_W-1:0]   n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_comb begin
        logic signed [VW-1:0] one, qs, v;
        one = VW'(1) <<< OUT_FRAC_BITS;
        for (int i = 0; i < NUM_ENT; i++) begin
            qs = $signed({2'b00, i_q[i]});
            if (i_zero) begin
                v = DIAG_MASK[i] ? one : '0;
            end else if (DIAG_MASK[i]) begin
                v = one - qs;
            end else begin
                v = i_neg[i] ? -qs : qs;
            end
            if (v > one) begin
                v = one;
            end else if (v < -one) begin
                v = -one;
            end
            n_data[i*OUT_W +: OUT_W] = OUT_W'(v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            o_data <= n_data;
        end
    end
endmodule
`default_nettype wire

// File: rtl/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix converter.
// The input stream carries one quaternion per request on the s_axis group: x, y and z
// as signed integers and w as signed fixed point with 8 fraction bits, packed from the
// low bits of tdata in that order. The output stream carries the nine matrix entries
// m00, m01, ... m22 in that order from the low bits of tdata, each a 16-bit signed value
// with OUT_FRAC_BITS fraction bits, rounded to nearest and clamped to plus or minus one.
// A zero quaternion gives the identity matrix.
// One request is accepted per cycle while s_axis tready is high. Stages in order:
// a register for the products, a register for the sums, one divider cell per
// quotient bit (OUT_FRAC_BITS + 4 cells in a row) and one output register.
// Every stage has its own valid flag, so bubbles close up and a stalled receiver
// backs up the row one stage at a time; s_axis tready drops only when all stages
// hold data. Reset clears all valid flags and leaves no result pending.
`default_nettype none
module quaternion_to_rotation_matrix import q2rm_pkg::*; #(
    parameter int IN_BITS       = IN_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // vec_x, vec_y, vec_z, scalar_w, zero pad
    input  wire logic [((4*IN_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [NUM_ENT*OUT_W-1:0]                 o_m_axis_tdata
);
    localparam int SW = 2 * IN_BITS + 18;
    localparam int RW = SW + OUT_FRAC_BITS + 5;
    localparam int QW = OUT_FRAC_BITS + 4;
    localparam int NC = QW;

    logic [NC:0]                        v, rdy;
    logic [NC:0][NUM_ENT-1:0][RW-1:0]   rem;
    logic [NC:0][NUM_ENT-1:0][QW-1:0]   q;
    logic [NC:0][SW:0]                  d;
    logic [NC:0][NUM_ENT-1:0]           neg;
    logic [NC:0]                        zero;

    assign q[0] = '0;

    q2rm_front #(
        .IN_BITS       (IN_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS),
        .SW            (SW),
        .RW            (RW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_x     (i_s_axis_tdata[0*IN_BITS +: IN_BITS]),
        .i_y     (i_s_axis_tdata[1*IN_BITS +: IN_BITS]),
        .i_z     (i_s_axis_tdata[2*IN_BITS +: IN_BITS]),
        .i_w     (i_s_axis_tdata[3*IN_BITS +: IN_BITS]),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_rem   (rem[0]),
        .o_d     (d[0]),
        .o_neg   (neg[0]),
        .o_zero  (zero[0])
    );

    for (genvar j = 0; j < NC; j++) begin : g_cell
        q2rm_div_cell #(
            .SW    (SW),
            .RW    (RW),
            .QW    (QW),
            .BIT_K (NC - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[j]),
            .o_ready (rdy[j]),
            .i_rem   (rem[j]),
            .i_q     (q[j]),
            .i_d     (d[j]),
            .i_neg   (neg[j]),
            .i_zero  (zero[j]),
            .o_valid (v[j+1]),
            .i_ready (rdy[j+1]),
            .o_rem   (rem[j+1]),
            .o_q     (q[j+1]),
            .o_d     (d[j+1]),
            .o_neg   (neg[j+1]),
            .o_zero  (zero[j+1])
        );
    end

    q2rm_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS),
        .QW            (QW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[NC]),
        .o_ready (rdy[NC]),
        .i_q     (q[NC]),
        .i_neg   (neg[NC]),
        .i_zero  (zero[NC]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );
endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import q2rm_pkg::*;

    localparam int FRAC = 14;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } quat_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    // vec_x, vec_y, vec_z, scalar_w
    logic [63:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    logic [NUM_ENT*OUT_W-1:0] o_m_axis_tdata;

    quaternion_to_rotation_matrix dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    quat_t pending_quats[$];
    logic [NUM_ENT*OUT_W-1:0] expected_mats[$];
    int send_idle_pct = 33;
    int recv_idle_pct = 64;
    int cycles = 0;
    int mismatches = 0;
    int matrices_seen = 0;
    int quats_sent = 0;

    // Rounded 2*p/s scaled by 2^FRAC, nearest with ties away from zero.
    function automatic longint scaled_ratio(logic signed [127:0] p, logic signed [127:0] s);
        logic [127:0] mag;
        logic [127:0] q;
        mag = p[127] ? -p : p;
        q = ((mag << (FRAC + 2)) + s) / (s << 1);
        return p[127] ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [15:0] clamp_entry(longint v);
        longint one;
        one = longint'(1) << FRAC;
        if (v > one) v = one;
        if (v < -one) v = -one;
        return v[15:0];
    endfunction

    function automatic logic [NUM_ENT*OUT_W-1:0] rotation_of(quat_t q);
        logic signed [127:0] x, y, z, w, s;
        longint one;
        longint m[9];
        logic [NUM_ENT*OUT_W-1:0] r;
        one = longint'(1) << FRAC;
        x = 128'(q.x) * 256;
        y = 128'(q.y) * 256;
        z = 128'(q.z) * 256;
        w = 128'(q.w);
        s = x * x + y * y + z * z + w * w;
        if (s == 0) begin
            m = '{one, 0, 0, 0, one, 0, 0, 0, one};
        end else begin
            m[0] = one - scaled_ratio(y * y + z * z, s);
            m[1] = scaled_ratio(x * y + z * w, s);
            m[2] = scaled_ratio(x * z - y * w, s);
            m[3] = scaled_ratio(x * y - z * w, s);
            m[4] = one - scaled_ratio(x * x + z * z, s);
            m[5] = scaled_ratio(y * z + x * w, s);
            m[6] = scaled_ratio(x * z + y * w, s);
            m[7] = scaled_ratio(y * z - x * w, s);
            m[8] = one - scaled_ratio(x * x + y * y, s);
        end
        for (int i = 0; i < 9; i++) r[i*OUT_W +: OUT_W] = clamp_entry(m[i]);
        return r;
    endfunction

    function automatic logic signed [15:0] pick_part();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            3: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_quat(int x, int y, int z, int w);
        quat_t q;
        q.x = 16'(x);
        q.y = 16'(y);
        q.z = 16'(z);
        q.w = 16'(w);
        pending_quats.push_back(q);
    endtask

    initial begin
        quat_t q;
        add_quat(0, 0, 0, 0);
        add_quat(0, 0, 0, 256);
        add_quat(0, 0, 0, -32768);
        add_quat(1, 0, 0, 0);
        add_quat(0, -1, 0, 0);
        add_quat(0, 0, 32767, 0);
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(1, 1, 1, 256);
        add_quat(1, 0, 0, 256);
        add_quat(0, 1, 0, -256);
        add_quat(0, 0, 0, 1);
        add_quat(0, 0, 0, -1);
        add_quat(1, 2, 3, 1);
        add_quat(-3, 1, 0, 5);
        add_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        add_quat(32767, 0, 0, 1);
        add_quat(1, 1, 0, 0);
        add_quat(1, -1, 0, 0);
        for (int i = 0; i < 750; i++) begin
            q.x = pick_part();
            q.y = pick_part();
            q.z = pick_part();
            q.w = pick_part();
            pending_quats.push_back(q);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == 11) i_rst_n <= 1'b1;
        if (cycles > LIMIT) begin
            $display("Timed out with %0d matrices outstanding.", expected_mats.size());
            $display("FAIL quaternion_to_rotation_matrix");
            $finish;
        end
    end

    // Driver: a request stays up until it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_mats.push_back(rotation_of(quat_t'(i_s_axis_tdata)));
                quats_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_quats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_axis_tdata <= pending_quats.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            matrices_seen++;
            if (expected_mats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected matrix %h", o_m_axis_tdata);
            end else begin
                logic [NUM_ENT*OUT_W-1:0] exp_mat;
                exp_mat = expected_mats.pop_front();
                for (int i = 0; i < NUM_ENT; i++) begin
                    if (o_m_axis_tdata[i*OUT_W +: OUT_W] !== exp_mat[i*OUT_W +: OUT_W]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Matrix %0d entry %0d: expected %h, got %h",
                                     matrices_seen, i, exp_mat[i*OUT_W +: OUT_W],
                                     o_m_axis_tdata[i*OUT_W +: OUT_W]);
                    end
                end
            end
        end
    end

    initial begin
        wait (quats_sent >= 270);
        send_idle_pct = 64;
        recv_idle_pct = 33;
        wait (quats_sent >= 520);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (pending_quats.size() == 0 && !i_s_axis_tvalid);
        wait (expected_mats.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("Sent %0d quaternions, checked %0d matrices under three idle patterns.",
                 quats_sent, matrices_seen);
        if (mismatches == 0 && expected_mats.size() == 0) begin
            $display("PASS quaternion_to_rotation_matrix");
        end else begin
            $display("%0d mismatches.", mismatches);
            $display("FAIL quaternion_to_rotation_matrix");
        end
        $finish;
    end
endmodule
